@@ rtl/grid_stability_window_monitor_assert.svh @@
// Assertion helpers for the monitor's top-level RTL.
`ifndef GRID_STABILITY_WINDOW_MONITOR_ASSERT_SVH
`define GRID_STABILITY_WINDOW_MONITOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define GSWM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gswm assertion failed");

// Next-cycle implication.
`define GSWM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gswm assertion failed");

`endif

@@ rtl/gswm_pkg.sv @@
`timescale 1ns / 1ps
package gswm_pkg;

   localparam int TIME_W    = 24;
   localparam int ELAPSED_W = 25;
   localparam int ANGLE_W   = 24;
   localparam int VOLT_W    = 16;
   localparam int FREQ_W    = 18;
   localparam int CAUSE_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam int ANGLE_LIM_W = 23;
   localparam int VOLT_LIM_W  = 15;
   localparam int FREQ_LIM_W  = 17;

   typedef logic [CAUSE_W-1:0]   cause_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [TIME_W-1:0]    time_type;

   // Register indexes on the configuration channel.
   localparam csr_idx_type REG_ANGLE_LIMIT     = 3'd0;
   localparam csr_idx_type REG_HIGH_VOLT_LIMIT = 3'd1;
   localparam csr_idx_type REG_HIGH_VOLT_TIME  = 3'd2;
   localparam csr_idx_type REG_LOW_VOLT_LIMIT  = 3'd3;
   localparam csr_idx_type REG_LOW_VOLT_TIME   = 3'd4;
   localparam csr_idx_type REG_HIGH_FREQ_LIMIT = 3'd5;
   localparam csr_idx_type REG_HIGH_FREQ_TIME  = 3'd6;
   localparam csr_idx_type REG_LOW_FREQ_LIMIT  = 3'd7;

   // Register reset values.
   localparam logic [ANGLE_LIM_W-1:0] ANGLE_LIMIT_RST     = 23'd18000;
   localparam logic [VOLT_LIM_W-1:0]  HIGH_VOLT_LIMIT_RST = 15'd11000;
   localparam time_type               HIGH_VOLT_TIME_RST  = 24'd5000;
   localparam logic [VOLT_LIM_W-1:0]  LOW_VOLT_LIMIT_RST  = 15'd7500;
   localparam time_type               LOW_VOLT_TIME_RST   = 24'd5000;
   localparam logic [FREQ_LIM_W-1:0]  HIGH_FREQ_LIMIT_RST = 17'd51000;
   localparam time_type               HIGH_FREQ_TIME_RST  = 24'd5000;
   localparam logic [FREQ_LIM_W-1:0]  LOW_FREQ_LIMIT_RST  = 17'd49000;

   // First-cause codes.
   localparam cause_type CAUSE_NONE      = 3'd0;
   localparam cause_type CAUSE_ANGLE     = 3'd1;
   localparam cause_type CAUSE_LOW_VOLT  = 3'd2;
   localparam cause_type CAUSE_HIGH_VOLT = 3'd3;
   localparam cause_type CAUSE_LOW_FREQ  = 3'd4;
   localparam cause_type CAUSE_HIGH_FREQ = 3'd5;

   typedef struct packed {
      logic                     first_row;
      logic [TIME_W-1:0]        time_stamp;
      logic signed [ANGLE_W-1:0] angle_spread;
      logic signed [VOLT_W-1:0] lowest_volt;
      logic signed [VOLT_W-1:0] highest_volt;
      logic signed [FREQ_W-1:0] lowest_freq;
      logic signed [FREQ_W-1:0] highest_freq;
   } row_type;

   // Per-row control handed to each duration detector.
   typedef struct packed {
      logic advance;
      logic clear;
      logic violating;
   } det_ctrl_type;

endpackage

@@ rtl/gswm_if.sv @@
`timescale 1ns / 1ps
interface gswm_req_if;
   import gswm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      first_row;
   logic [TIME_W-1:0]         time_stamp;
   logic signed [ANGLE_W-1:0] angle_spread;
   logic signed [VOLT_W-1:0]  lowest_volt;
   logic signed [VOLT_W-1:0]  highest_volt;
   logic signed [FREQ_W-1:0]  lowest_freq;
   logic signed [FREQ_W-1:0]  highest_freq;

   modport source (output valid, first_row, time_stamp, angle_spread, lowest_volt,
                   highest_volt, lowest_freq, highest_freq, input ready);
   modport sink (input valid, first_row, time_stamp, angle_spread, lowest_volt,
                 highest_volt, lowest_freq, highest_freq, output ready);
endinterface

interface gswm_rsp_if;
   import gswm_pkg::*;
   logic               valid;
   logic               ready;
   logic               insecure;
   logic [CAUSE_W-1:0] cause;

   modport source (output valid, insecure, cause, input ready);
   modport sink (input valid, insecure, cause, output ready);
endinterface

interface gswm_csr_if;
   import gswm_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/grid_stability_window_monitor.sv @@
`timescale 1ns / 1ps
// An accepted word enters the input register; its response comes from the verdict register.
// Throughput: one word per cycle; the input register feeds the detectors and the
// verdict register in one pass, so the only stall is a held response.
// Reset (synchronous): configuration registers return to their defaults, the
// detectors and the latched verdict clear, and both pipeline stages empty.
module grid_stability_window_monitor #(
   parameter int LOW_FREQ_TIME_LIMIT = 5000
) (
   input logic     clock,
   input logic     reset,
   gswm_req_if.sink   req_ch,
   gswm_rsp_if.source rsp_ch,
   gswm_csr_if.sink   csr_ch
);
   import gswm_pkg::*;

   `include "grid_stability_window_monitor_assert.svh"

   localparam time_type LF_ALLOWED = TIME_W'(LOW_FREQ_TIME_LIMIT);

   logic [ANGLE_LIM_W-1:0] angle_limit_ff;
   logic [VOLT_LIM_W-1:0]  high_volt_limit_ff, low_volt_limit_ff;
   time_type               high_volt_time_ff, low_volt_time_ff, high_freq_time_ff;
   logic [FREQ_LIM_W-1:0]  high_freq_limit_ff, low_freq_limit_ff;

   row_type   row_ff, row_in;
   logic      row_valid_ff, row_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      verdict_ff, verdict_in;
   cause_type cause_ff, cause_in;
   logic      fire;

   logic [ANGLE_W-1:0] ang_mag;
   logic [VOLT_W-1:0]  lv_mag, hv_mag;
   logic [FREQ_W-1:0]  lf_mag, hf_mag;
   logic               angle_hit;
   logic [3:0]         det_viol, det_over;
   det_ctrl_type       det_ctrl [4];
   time_type           det_allowed [4];
   logic               verdict_eff;

   // Configuration channel.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_limit_ff     <= ANGLE_LIMIT_RST;
         high_volt_limit_ff <= HIGH_VOLT_LIMIT_RST;
         high_volt_time_ff  <= HIGH_VOLT_TIME_RST;
         low_volt_limit_ff  <= LOW_VOLT_LIMIT_RST;
         low_volt_time_ff   <= LOW_VOLT_TIME_RST;
         high_freq_limit_ff <= HIGH_FREQ_LIMIT_RST;
         high_freq_time_ff  <= HIGH_FREQ_TIME_RST;
         low_freq_limit_ff  <= LOW_FREQ_LIMIT_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_ANGLE_LIMIT:     angle_limit_ff     <= csr_ch.data[ANGLE_LIM_W-1:0];
            REG_HIGH_VOLT_LIMIT: high_volt_limit_ff <= csr_ch.data[VOLT_LIM_W-1:0];
            REG_HIGH_VOLT_TIME:  high_volt_time_ff  <= csr_ch.data[TIME_W-1:0];
            REG_LOW_VOLT_LIMIT:  low_volt_limit_ff  <= csr_ch.data[VOLT_LIM_W-1:0];
            REG_LOW_VOLT_TIME:   low_volt_time_ff   <= csr_ch.data[TIME_W-1:0];
            REG_HIGH_FREQ_LIMIT: high_freq_limit_ff <= csr_ch.data[FREQ_LIM_W-1:0];
            REG_HIGH_FREQ_TIME:  high_freq_time_ff  <= csr_ch.data[TIME_W-1:0];
            REG_LOW_FREQ_LIMIT:  low_freq_limit_ff  <= csr_ch.data[FREQ_LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // The row in the input register moves on whenever the response slot is free
   // or is being emptied in this cycle.
   assign fire         = row_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !row_valid_ff || fire;

   always_comb begin
      row_in.first_row    = req_ch.first_row;
      row_in.time_stamp   = req_ch.time_stamp;
      row_in.angle_spread = req_ch.angle_spread;
      row_in.lowest_volt  = req_ch.lowest_volt;
      row_in.highest_volt = req_ch.highest_volt;
      row_in.lowest_freq  = req_ch.lowest_freq;
      row_in.highest_freq = req_ch.highest_freq;
      row_valid_in = req_ch.valid ? 1'b1 : (fire ? 1'b0 : row_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         row_ff <= row_in;
      end
   end

   // Magnitudes: the most negative code maps to its true unsigned size.
   always_comb begin
      ang_mag = row_ff.angle_spread[ANGLE_W-1] ? ANGLE_W'(-row_ff.angle_spread)
                                               : ANGLE_W'(row_ff.angle_spread);
      lv_mag  = row_ff.lowest_volt[VOLT_W-1] ? VOLT_W'(-row_ff.lowest_volt)
                                             : VOLT_W'(row_ff.lowest_volt);
      hv_mag  = row_ff.highest_volt[VOLT_W-1] ? VOLT_W'(-row_ff.highest_volt)
                                              : VOLT_W'(row_ff.highest_volt);
      lf_mag  = row_ff.lowest_freq[FREQ_W-1] ? FREQ_W'(-row_ff.lowest_freq)
                                             : FREQ_W'(row_ff.lowest_freq);
      hf_mag  = row_ff.highest_freq[FREQ_W-1] ? FREQ_W'(-row_ff.highest_freq)
                                              : FREQ_W'(row_ff.highest_freq);

      angle_hit   = ang_mag >= ANGLE_W'(angle_limit_ff);
      det_viol[0] = lv_mag < VOLT_W'(low_volt_limit_ff);
      det_viol[1] = hv_mag > VOLT_W'(high_volt_limit_ff);
      det_viol[2] = lf_mag < FREQ_W'(low_freq_limit_ff);
      det_viol[3] = hf_mag > FREQ_W'(high_freq_limit_ff);

      det_allowed[0] = low_volt_time_ff;
      det_allowed[1] = high_volt_time_ff;
      det_allowed[2] = LF_ALLOWED;
      det_allowed[3] = high_freq_time_ff;
   end

   // Detector order: low volt, high volt, low freq, high freq.
   for (genvar d = 0; d < 4; d++) begin : g_det
      assign det_ctrl[d] = '{advance: fire, clear: row_ff.first_row,
                             violating: det_viol[d]};
      gswm_detector u_det (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (det_ctrl[d]),
         .time_stamp (row_ff.time_stamp),
         .allowed    (det_allowed[d]),
         .over       (det_over[d])
      );
   end

   // Verdict latch; the lowest cause code wins within one row.
   always_comb begin
      verdict_eff = verdict_ff & ~row_ff.first_row;
      verdict_in  = verdict_eff;
      cause_in    = row_ff.first_row ? CAUSE_NONE : cause_ff;
      if (!verdict_eff) begin
         verdict_in = 1'b1;
         if (angle_hit) begin
            cause_in = CAUSE_ANGLE;
         end else if (det_over[0]) begin
            cause_in = CAUSE_LOW_VOLT;
         end else if (det_over[1]) begin
            cause_in = CAUSE_HIGH_VOLT;
         end else if (det_over[2]) begin
            cause_in = CAUSE_LOW_FREQ;
         end else if (det_over[3]) begin
            cause_in = CAUSE_HIGH_FREQ;
         end else begin
            verdict_in = 1'b0;
            cause_in   = CAUSE_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         verdict_ff <= 1'b0;
         cause_ff   <= CAUSE_NONE;
      end else if (fire) begin
         verdict_ff <= verdict_in;
         cause_ff   <= cause_in;
      end
   end

   // The verdict register doubles as the response payload: it only changes
   // when a new row moves into the response slot.
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.insecure = verdict_ff;
   assign rsp_ch.cause    = cause_ff;

   `GSWM_ASSERT_IMP(a_cause_matches_verdict, clock, reset, rsp_valid_ff,
                    verdict_ff == (cause_ff != CAUSE_NONE))
   `GSWM_ASSERT_NXT(a_verdict_latches, clock, reset,
                    fire && verdict_ff && !row_ff.first_row,
                    verdict_ff && (cause_ff == $past(cause_ff)))
   `GSWM_ASSERT_NXT(a_stalled_row_kept, clock, reset, row_valid_ff && !fire,
                    row_valid_ff && rsp_valid_ff)

endmodule

@@ rtl/gswm_detector.sv @@
`timescale 1ns / 1ps
module gswm_detector (
   input  logic                   clock,
   input  logic                   reset,
   input  gswm_pkg::det_ctrl_type ctrl,
   input  gswm_pkg::time_type     time_stamp,
   input  gswm_pkg::time_type     allowed,
   output logic                   over
);
   import gswm_pkg::*;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

   logic                 active_ff, active_in;
   logic [TIME_W-1:0]    last_ff, last_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;

   logic                 act_eff;
   logic [TIME_W-1:0]    last_eff;
   logic [ELAPSED_W-1:0] elapsed_eff;
   logic [ELAPSED_W:0]   sum;

   always_comb begin
      // A first row starts the case from a cleared detector.
      act_eff     = active_ff & ~ctrl.clear;
      last_eff    = ctrl.clear ? '0 : last_ff;
      elapsed_eff = ctrl.clear ? '0 : elapsed_ff;
      sum = {1'b0, elapsed_eff} + (ELAPSED_W+1)'(time_stamp - last_eff);

      active_in  = 1'b0;
      last_in    = '0;
      elapsed_in = '0;
      if (ctrl.violating) begin
         active_in = 1'b1;
         last_in   = time_stamp;
         if (!act_eff) begin
            elapsed_in = '0;
         end else if (time_stamp > last_eff) begin
            elapsed_in = sum[ELAPSED_W] ? ELAPSED_MAX : sum[ELAPSED_W-1:0];
         end else begin
            elapsed_in = elapsed_eff;
         end
      end
      over = ctrl.violating && (elapsed_in > {1'b0, allowed});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         last_ff    <= '0;
         elapsed_ff <= '0;
      end else if (ctrl.advance) begin
         active_ff  <= active_in;
         last_ff    <= last_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule
